>>> rtl/lock_order_cycle_detector_assert.svh
// Assertion macros used by the top-level lock-order checker.
`ifndef LOCK_ORDER_CYCLE_DETECTOR_ASSERT_SVH
`define LOCK_ORDER_CYCLE_DETECTOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define LOCD_ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define LOCD_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define LOCD_ASSERT_IMPL(label, clk, rstn, prop)
`define LOCD_ASSERT_RST(label, clk, prop)
`endif
`endif

>>> rtl/locd_pkg.sv
package locd_pkg;

    localparam int NUM_LOCKS_DEF   = 32;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int ID_W            = 5;
    localparam int STATUS_W        = 3;
    localparam int COUNT_W         = 5;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_WRONG    = 3'd2,
        ST_DEADLOCK = 3'd3,
        ST_OVERFLOW = 3'd4,
        ST_HALTED   = 3'd5
    } status_t;

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

endpackage

>>> rtl/locd_dfs.sv
// Iterative depth-first search over the order graph from each unvisited root.
// In the walk state each cycle reads the adjacency row of the node on top of
// the path: it pushes the lowest open successor, pops or flags a back edge.
module locd_dfs #(
    parameter int NUM_LOCKS = locd_pkg::NUM_LOCKS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    output logic [$clog2(NUM_LOCKS)-1:0]  row_addr,
    input  logic [NUM_LOCKS-1:0]          row_data,
    output logic                          done,
    output logic                          cycle_found
);
    import locd_pkg::*;

    localparam int NW = $clog2(NUM_LOCKS);
    localparam int SPW = $clog2(NUM_LOCKS + 1);

    typedef enum logic [1:0] {S_IDLE, S_ROOT, S_WALK} state_t;

    state_t                 state_reg;
    logic [NUM_LOCKS-1:0]   visited_reg;
    logic [NUM_LOCKS-1:0]   finished_reg;
    logic [NW-1:0]          walk_mem [NUM_LOCKS];
    logic [NW-1:0]          top_reg;
    logic [SPW-1:0]         sp_reg;
    logic [NW:0]            root_reg;
    logic                   done_reg;
    logic                   found_reg;

    logic [NUM_LOCKS-1:0]   open_bits;
    logic                   any_open;
    logic [NW-1:0]          first_open;

    assign row_addr  = top_reg;
    assign open_bits = row_data & ~finished_reg;
    assign any_open  = |open_bits;

    always_comb begin
        first_open = '0;
        for (int i = NUM_LOCKS - 1; i >= 0; i--) begin
            if (open_bits[i]) begin
                first_open = NW'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        done_reg <= 1'b0;
        if (!aresetn) begin
            state_reg <= S_IDLE;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        visited_reg  <= '0;
                        finished_reg <= '0;
                        root_reg     <= '0;
                        found_reg    <= 1'b0;
                        state_reg    <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (root_reg == (NW+1)'(NUM_LOCKS)) begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end else if (visited_reg[root_reg[NW-1:0]]) begin
                        root_reg <= root_reg + 1'b1;
                    end else begin
                        visited_reg[root_reg[NW-1:0]] <= 1'b1;
                        walk_mem[0] <= root_reg[NW-1:0];
                        top_reg     <= root_reg[NW-1:0];
                        sp_reg      <= SPW'(1);
                        root_reg    <= root_reg + 1'b1;
                        state_reg   <= S_WALK;
                    end
                end
                S_WALK: begin
                    if ((open_bits & visited_reg) != '0) begin
                        found_reg <= 1'b1;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end else if (any_open) begin
                        // The path never exceeds the node count, since each
                        // pushed node was unvisited.
                        visited_reg[first_open] <= 1'b1;
                        walk_mem[sp_reg[NW-1:0]] <= first_open;
                        top_reg <= first_open;
                        sp_reg  <= sp_reg + 1'b1;
                    end else begin
                        finished_reg[top_reg] <= 1'b1;
                        sp_reg <= sp_reg - 1'b1;
                        if (sp_reg == SPW'(1)) begin
                            state_reg <= S_ROOT;
                        end else begin
                            top_reg <= walk_mem[sp_reg[NW-1:0] - NW'(2)];
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done        = done_reg;
    assign cycle_found = found_reg;

endmodule

>>> rtl/lock_order_cycle_detector.sv
// Lock-order checker: each item acquires or releases a lock id; one result
// item follows each input item. Releases, repeated acquires, errors and
// acquires that add no new order edge go straight to the output stage.
// An acquire that records a new order edge starts a depth-first search of
// the whole graph, one node step per cycle through a single adjacency-row
// read. The order graph clears on reset through a per-row valid bit, so no
// clearing pass is needed. The block accepts no item while a search runs or
// a result waits.
module lock_order_cycle_detector #(
    parameter int NUM_LOCKS   = locd_pkg::NUM_LOCKS_DEF,
    parameter int STACK_DEPTH = locd_pkg::STACK_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [0] cmd, [5:1] lock_id
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [2:0] status, [7:3] held_count
    output logic       m_tuser    // [0] edge_added
);
    import locd_pkg::*;

    `include "lock_order_cycle_detector_assert.svh"

    localparam int NW = $clog2(NUM_LOCKS);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int HW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_OUT} state_t;

    state_t                state_reg;
    logic [NUM_LOCKS-1:0]  edges_mem [NUM_LOCKS];
    logic [NUM_LOCKS-1:0]  row_valid_reg;
    logic [NW-1:0]         held_mem [STACK_DEPTH];
    logic [DW-1:0]         depth_reg;
    logic                  halted_reg;
    logic [NW-1:0]         new_id_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic                  added_reg;
    logic                  start_reg;

    logic                  cmd;
    logic [NW-1:0]         id;
    logic [NW-1:0]         top_id;
    logic [NUM_LOCKS-1:0]  top_row;
    logic [NW-1:0]         dfs_addr;
    logic [NUM_LOCKS-1:0]  dfs_row;
    logic                  dfs_done;
    logic                  dfs_found;
    logic                  in_fire;

    assign cmd     = s_tdata[0];

    // The raw lock id wraps modulo NUM_LOCKS through a small constant table.
    always_comb begin
        id = '0;
        for (int i = 0; i < 32; i++) begin
            if (s_tdata[5:1] == 5'(i)) begin
                id = NW'(i % NUM_LOCKS);
            end
        end
    end

    assign top_id  = held_mem[HW'(depth_reg - 1'b1)];
    assign top_row = row_valid_reg[top_id] ? edges_mem[top_id] : '0;
    assign dfs_row = row_valid_reg[dfs_addr] ? edges_mem[dfs_addr] : '0;
    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    locd_dfs #(.NUM_LOCKS(NUM_LOCKS)) u_dfs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (start_reg),
        .row_addr    (dfs_addr),
        .row_data    (dfs_row),
        .done        (dfs_done),
        .cycle_found (dfs_found)
    );

    always_ff @(posedge aclk) begin
        start_reg <= 1'b0;
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            row_valid_reg <= '0;
            depth_reg     <= '0;
            halted_reg    <= 1'b0;
            start_reg     <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        added_reg  <= 1'b0;
                        status_reg <= ST_OK;
                        state_reg  <= S_OUT;
                        if (halted_reg) begin
                            status_reg <= ST_HALTED;
                        end else if (cmd == CMD_ACQUIRE) begin
                            if (depth_reg == DW'(STACK_DEPTH)) begin
                                status_reg <= ST_OVERFLOW;
                                halted_reg <= 1'b1;
                            end else if (depth_reg != '0 && top_id != id
                                         && !top_row[id]) begin
                                edges_mem[top_id]     <= top_row | (NUM_LOCKS'(1) << id);
                                row_valid_reg[top_id] <= 1'b1;
                                added_reg  <= 1'b1;
                                new_id_reg <= id;
                                start_reg  <= 1'b1;
                                state_reg  <= S_SEARCH;
                            end else begin
                                held_mem[HW'(depth_reg)] <= id;
                                depth_reg <= depth_reg + 1'b1;
                            end
                        end else begin
                            if (depth_reg == '0) begin
                                status_reg <= ST_EMPTY;
                                halted_reg <= 1'b1;
                            end else if (top_id != id) begin
                                status_reg <= ST_WRONG;
                                halted_reg <= 1'b1;
                            end else begin
                                depth_reg <= depth_reg - 1'b1;
                            end
                        end
                    end
                end
                S_SEARCH: begin
                    if (dfs_done) begin
                        state_reg <= S_OUT;
                        if (dfs_found) begin
                            status_reg <= ST_DEADLOCK;
                            halted_reg <= 1'b1;
                        end else begin
                            held_mem[HW'(depth_reg)] <= new_id_reg;
                            depth_reg <= depth_reg + 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    if (m_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {COUNT_W'(depth_reg), status_reg};
    assign m_tuser  = added_reg;

    `LOCD_ASSERT_IMPL(a_depth_bound, aclk, aresetn, depth_reg <= DW'(STACK_DEPTH))
    `LOCD_ASSERT_IMPL(a_halt_sticky, aclk, aresetn, $past(halted_reg) |-> halted_reg)
    `LOCD_ASSERT_IMPL(a_dead_edge, aclk, aresetn, (m_tvalid && status_reg == ST_DEADLOCK) |-> added_reg)
    `LOCD_ASSERT_IMPL(a_search_start, aclk, aresetn, start_reg |-> state_reg == S_SEARCH)

endmodule

>>> sim/lock_order_cycle_detector_test.sv
module lock_order_cycle_detector_test;
    import locd_pkg::*;

    localparam int NUM_ITEMS   = 1600;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DEPTH       = STACK_DEPTH_DEF;

    typedef struct packed {
        status_t    st;
        logic [4:0] cnt;
        logic       add;
    } outcome_t;

    typedef struct {
        logic       cmd;
        logic [4:0] id;
        bit         typed;
        outcome_t   want;
    } row_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tuser;

    // Shadow copy of the lock tracker.
    logic [4:0]  held_ids [DEPTH];
    int          held_n;
    logic [31:0] order_rows [32];
    bit          stopped;

    outcome_t pending [$];
    int       failures;
    int       items_sent;
    int       edges_seen;
    int       deepest;
    int       cycles;
    int       hold_cycles;
    bit       quiet;

    row_t head_rows [11] = '{
        '{CMD_ACQUIRE, 5'd0,  1'b1, '{ST_OK, 5'd1, 1'b0}},
        '{CMD_ACQUIRE, 5'd0,  1'b1, '{ST_OK, 5'd2, 1'b0}},
        '{CMD_ACQUIRE, 5'd31, 1'b1, '{ST_OK, 5'd3, 1'b1}},
        '{CMD_RELEASE, 5'd31, 1'b1, '{ST_OK, 5'd2, 1'b0}},
        '{CMD_RELEASE, 5'd0,  1'b1, '{ST_OK, 5'd1, 1'b0}},
        '{CMD_RELEASE, 5'd0,  1'b1, '{ST_OK, 5'd0, 1'b0}},
        '{CMD_ACQUIRE, 5'd31, 1'b0, '{ST_OK, 5'd0, 1'b0}},
        '{CMD_ACQUIRE, 5'd30, 1'b0, '{ST_OK, 5'd0, 1'b0}},
        '{CMD_ACQUIRE, 5'd21, 1'b0, '{ST_OK, 5'd0, 1'b0}},
        '{CMD_RELEASE, 5'd21, 1'b0, '{ST_OK, 5'd0, 1'b0}},
        '{CMD_RELEASE, 5'd30, 1'b0, '{ST_OK, 5'd0, 1'b0}}
    };

    // Runs with the stack empty; taking 7 after 9 closes a two-lock cycle.
    row_t tail_rows [9] = '{
        '{CMD_ACQUIRE, 5'd7,  1'b0, '{ST_OK, 5'd0, 1'b0}},
        '{CMD_ACQUIRE, 5'd9,  1'b0, '{ST_OK, 5'd0, 1'b0}},
        '{CMD_RELEASE, 5'd9,  1'b0, '{ST_OK, 5'd0, 1'b0}},
        '{CMD_RELEASE, 5'd7,  1'b0, '{ST_OK, 5'd0, 1'b0}},
        '{CMD_ACQUIRE, 5'd9,  1'b1, '{ST_OK, 5'd1, 1'b0}},
        '{CMD_ACQUIRE, 5'd7,  1'b1, '{ST_DEADLOCK, 5'd1, 1'b1}},
        '{CMD_RELEASE, 5'd9,  1'b1, '{ST_HALTED, 5'd1, 1'b0}},
        '{CMD_ACQUIRE, 5'd0,  1'b1, '{ST_HALTED, 5'd1, 1'b0}},
        '{CMD_RELEASE, 5'd31, 1'b1, '{ST_HALTED, 5'd1, 1'b0}}
    };

    lock_order_cycle_detector i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic bit graph_loops(input logic [31:0] g [32]);
        logic [31:0] seen;
        logic [31:0] finished;
        logic [31:0] open;
        logic [4:0]  path [32];
        int          sp;
        int          u;
        bit          pushed;
        seen = '0;
        finished = '0;
        for (int root = 0; root < 32; root++) begin
            if (seen[root]) continue;
            seen[root] = 1'b1;
            path[0] = root[4:0];
            sp = 1;
            while (sp > 0) begin
                u = path[sp-1];
                open = g[u] & ~finished;
                if ((open & seen) != '0) return 1'b1;
                pushed = 1'b0;
                for (int v = 0; v < 32; v++) begin
                    if (open[v]) begin
                        seen[v] = 1'b1;
                        path[sp] = v[4:0];
                        sp++;
                        pushed = 1'b1;
                        break;
                    end
                end
                if (!pushed) begin
                    finished[u] = 1'b1;
                    sp--;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic outcome_t track_lock(input logic cmd, input logic [4:0] id);
        outcome_t   r;
        logic [4:0] top;
        bit         dead;
        r.st = ST_OK;
        r.add = 1'b0;
        if (stopped) begin
            r.st = ST_HALTED;
        end else if (cmd == CMD_ACQUIRE) begin
            if (held_n >= DEPTH) begin
                r.st = ST_OVERFLOW;
                stopped = 1'b1;
            end else begin
                dead = 1'b0;
                if (held_n > 0) begin
                    top = held_ids[held_n-1];
                    if (top != id && !order_rows[top][id]) begin
                        order_rows[top][id] = 1'b1;
                        r.add = 1'b1;
                        dead = graph_loops(order_rows);
                    end
                end
                if (dead) begin
                    r.st = ST_DEADLOCK;
                    stopped = 1'b1;
                end else begin
                    held_ids[held_n] = id;
                    held_n++;
                end
            end
        end else begin
            if (held_n == 0) begin
                r.st = ST_EMPTY;
                stopped = 1'b1;
            end else if (held_ids[held_n-1] != id) begin
                r.st = ST_WRONG;
                stopped = 1'b1;
            end else begin
                held_n--;
            end
        end
        r.cnt = held_n[4:0];
        return r;
    endfunction

    task automatic send_item(input logic cmd, input logic [4:0] id, input bit typed,
                             input outcome_t want);
        outcome_t got;
        s_tdata  <= {2'b00, id, cmd};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        got = track_lock(cmd, id);
        pending.push_back(typed ? want : got);
        items_sent++;
        if (got.add) edges_seen++;
        if (held_n > deepest) deepest = held_n;
        if (!quiet && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        while (pending.size() != 0) @(posedge aclk);
    endtask

    // Result side: checks each accepted item and throttles m_tready.
    initial begin
        outcome_t exp_r;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pending.size() == 0) begin
                    $error("result item with nothing expected: tdata %h", m_tdata);
                    failures++;
                end else begin
                    exp_r = pending.pop_front();
                    if (m_tdata[2:0] !== exp_r.st) begin
                        $error("status: expected %0d, got %0d", exp_r.st, m_tdata[2:0]);
                        failures++;
                    end
                    if (m_tdata[7:3] !== exp_r.cnt) begin
                        $error("held_count: expected %0d, got %0d", exp_r.cnt, m_tdata[7:3]);
                        failures++;
                    end
                    if (m_tuser !== exp_r.add) begin
                        $error("edge_added: expected %0d, got %0d", exp_r.add, m_tuser);
                        failures++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_tready <= quiet || ($urandom_range(99) >= 8);
            end
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic       cmd;
        logic [4:0] id;
        logic [4:0] top;
        logic [31:0] trial [32];
        outcome_t   none;
        int         n;
        none = '{ST_OK, 5'd0, 1'b0};
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        held_n = 0;
        stopped = 1'b0;
        foreach (order_rows[i]) order_rows[i] = '0;
        failures = 0;
        items_sent = 0;
        edges_seen = 0;
        deepest = 0;
        hold_cycles = 0;
        quiet = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (head_rows[i])
            send_item(head_rows[i].cmd, head_rows[i].id, head_rows[i].typed,
                      head_rows[i].want);

        // Well-formed traffic only: releases pop the top, and acquires that
        // would close a cycle are skipped so the tracker never halts early.
        // The graph also stays acyclic with the edge 7 -> 9 added, so no path
        // from 9 to 7 exists when the closing sequence runs.
        n = 0;
        while (n < NUM_ITEMS) begin
            if (n == 300) hold_cycles = 400;
            if (n == 700) drain_results();
            quiet = (n >= 900 && n < 1100);
            if (held_n > 0 && (held_n == DEPTH || $urandom_range(99) < 40)) begin
                cmd = CMD_RELEASE;
                id = held_ids[held_n-1];
            end else begin
                cmd = CMD_ACQUIRE;
                id = $urandom_range(31);
                if (held_n > 0) begin
                    top = held_ids[held_n-1];
                    if (top != id && !order_rows[top][id]) begin
                        trial = order_rows;
                        trial[top][id] = 1'b1;
                        trial[7][9] = 1'b1;
                        if (graph_loops(trial)) continue;
                    end
                end
            end
            send_item(cmd, id, 1'b0, none);
            n++;
        end
        quiet = 1'b0;

        while (held_n > 0) send_item(CMD_RELEASE, held_ids[held_n-1], 1'b0, none);
        foreach (tail_rows[i])
            send_item(tail_rows[i].cmd, tail_rows[i].id, tail_rows[i].typed,
                      tail_rows[i].want);
        s_tvalid <= 1'b0;

        drain_results();
        repeat (200) @(posedge aclk);
        $display("Covered %0d items, %0d new order edges, stack depth up to %0d,",
                 items_sent, edges_seen, deepest);
        $display("then a deadlock and the halted state; %0d mismatches.", failures);
        if (failures == 0 && pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/locd_pkg.sv
rtl/locd_dfs.sv
rtl/lock_order_cycle_detector.sv
sim/lock_order_cycle_detector_test.sv
